FILE: src/ppl_pkg.sv
package ppl_pkg;

    localparam int REG_W      = 10;
    localparam int POS_W      = 12;
    localparam int IDX_OUT_W  = 5;
    localparam int CNT_OUT_W  = 6;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [REG_W-1:0] LINK_RADIUS_RST  = 10'd200;
    localparam logic [REG_W-1:0] ADD_INTERVAL_RST = 10'd100;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_CLEAR = 1'b1
    } t_op;

    typedef enum logic {
        REG_LINK_RADIUS  = 1'b0,
        REG_ADD_INTERVAL = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINAL
    } t_state;

endpackage

FILE: src/ppl_cell.sv
module ppl_cell #(
    parameter int W = 36
) (
    input  logic         i_clk,
    input  logic         i_load,
    input  logic         i_shift,
    input  logic [W-1:0] i_load_data,
    input  logic [W-1:0] i_next,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_load_data;
        end else if (i_shift) begin
            r_data <= i_next;
        end
    end

    assign o_data = r_data;

endmodule

FILE: src/ppl_dist.sv
module ppl_dist #(
    parameter int COORD_BITS = 12,
    parameter int IDX_W      = 5
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [IDX_W-1:0]            i_idx,
    input  logic [3*COORD_BITS-1:0]     i_point,
    input  logic [3*COORD_BITS-1:0]     i_probe,
    input  logic [2*ppl_pkg::REG_W-1:0] i_r2,
    output logic                        o_hit,
    output logic [IDX_W-1:0]            o_idx,
    output logic                        o_busy
);

    localparam int C  = COORD_BITS;
    localparam int QW = 2 * C + 2;
    localparam int SW = 2 * C + 4;

    logic signed [C:0]   w_dx;
    logic signed [C:0]   w_dy;
    logic signed [C:0]   w_dz;
    logic signed [C:0]   r_dx;
    logic signed [C:0]   r_dy;
    logic signed [C:0]   r_dz;
    logic                r_v1;
    logic [IDX_W-1:0]    r_idx1;
    logic [QW-1:0]       r_sx;
    logic [QW-1:0]       r_sy;
    logic [QW-1:0]       r_sz;
    logic                r_v2;
    logic [IDX_W-1:0]    r_idx2;
    logic [SW-1:0]       w_sum;

    assign w_dx = $signed({i_point[C-1], i_point[C-1:0]})
                - $signed({i_probe[C-1], i_probe[C-1:0]});
    assign w_dy = $signed({i_point[2*C-1], i_point[2*C-1:C]})
                - $signed({i_probe[2*C-1], i_probe[2*C-1:C]});
    assign w_dz = $signed({i_point[3*C-1], i_point[3*C-1:2*C]})
                - $signed({i_probe[3*C-1], i_probe[3*C-1:2*C]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx   <= w_dx;
            r_dy   <= w_dy;
            r_dz   <= w_dz;
            r_idx1 <= i_idx;
            r_sx   <= $unsigned(QW'(r_dx) * QW'(r_dx));
            r_sy   <= $unsigned(QW'(r_dy) * QW'(r_dy));
            r_sz   <= $unsigned(QW'(r_dz) * QW'(r_dz));
            r_idx2 <= r_idx1;
        end
    end

    assign w_sum  = SW'(r_sx) + SW'(r_sy) + SW'(r_sz);
    assign o_hit  = r_v2 && (w_sum <= SW'(i_r2));
    assign o_idx  = r_idx2;
    assign o_busy = r_v1 || r_v2;

endmodule

FILE: src/proximity_pair_linker.sv
// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_stall   i_op, i_pos_x, i_pos_y, i_pos_z
// output    out        o_out_valid / i_out_stall o_added, o_has_pair, o_first_index,
//                                                o_second_index, o_point_count, o_last
// config    in         psel / penable / pwrite   paddr, pwdata, prdata, pready
//
// A clear or a tick that stores no point gives one transfer.
// A tick that stores a point starts a scan: the stored points rotate once around the
// ring of cells past a two-stage distance unit, the unit drains, then one final
// result is formed.
// Reset is synchronous and clears the count, the phase and the registers; the point
// store holds no reset value and needs no clearing pass.
// While the output stage holds an untaken transfer, the ring and the distance unit wait.
module proximity_pair_linker #(
    parameter int MAX_POINTS = 32,
    parameter int COORD_BITS = 12
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic                                    i_op,
    input  logic signed [ppl_pkg::POS_W-1:0]        i_pos_x,
    input  logic signed [ppl_pkg::POS_W-1:0]        i_pos_y,
    input  logic signed [ppl_pkg::POS_W-1:0]        i_pos_z,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic                                    o_added,
    output logic                                    o_has_pair,
    output logic [ppl_pkg::IDX_OUT_W-1:0]           o_first_index,
    output logic [ppl_pkg::IDX_OUT_W-1:0]           o_second_index,
    output logic [ppl_pkg::CNT_OUT_W-1:0]           o_point_count,
    output logic                                    o_last,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [ppl_pkg::APB_ADDR_W-1:0]          paddr,
    input  logic [ppl_pkg::APB_DATA_W-1:0]          pwdata,
    output logic [ppl_pkg::APB_DATA_W-1:0]          prdata,
    output logic                                    pready
);

    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int PW = 3 * COORD_BITS;
    localparam int RW = ppl_pkg::REG_W;
    localparam logic [IW-1:0] SCAN_LAST = IW'(MAX_POINTS - 1);

    ppl_pkg::t_state                 r_state;
    ppl_pkg::t_state                 n_state;
    logic [CW-1:0]                   r_count;
    logic [CW-1:0]                   n_count;
    logic [RW-1:0]                   r_phase;
    logic [RW-1:0]                   n_phase;
    logic [IW-1:0]                   r_scan;
    logic [IW-1:0]                   n_scan;
    logic [CW-1:0]                   r_new_idx;
    logic [CW-1:0]                   n_new_idx;
    logic                            r_pend_v;
    logic                            n_pend_v;
    logic [IW-1:0]                   r_pend_idx;
    logic [IW-1:0]                   n_pend_idx;
    logic [PW-1:0]                   r_probe;
    logic [RW-1:0]                   r_radius;
    logic [RW-1:0]                   r_interval;
    logic [2*RW-1:0]                 r_r2;

    logic                            r_out_valid;
    logic                            r_out_added;
    logic                            r_out_has_pair;
    logic [ppl_pkg::IDX_OUT_W-1:0]   r_out_first;
    logic [ppl_pkg::IDX_OUT_W-1:0]   r_out_second;
    logic [ppl_pkg::CNT_OUT_W-1:0]   r_out_count;
    logic                            r_out_last;
    logic                            n_out_added;
    logic                            n_out_has_pair;
    logic [ppl_pkg::IDX_OUT_W-1:0]   n_out_first;
    logic [ppl_pkg::IDX_OUT_W-1:0]   n_out_second;
    logic                            n_out_last;
    logic                            out_load;

    logic                            adv;
    logic                            accept_in;
    logic                            is_clear;
    logic                            do_add;
    logic                            start;
    logic                            ring_shift;
    logic [RW:0]                     phase_inc;
    logic [RW-1:0]                   interval_eff;
    logic [RW-1:0]                   phase_next;
    logic [PW-1:0]                   in_point;
    logic [PW-1:0]                   w_cell_data [MAX_POINTS];
    logic                            dist_valid;
    logic                            dist_hit;
    logic [IW-1:0]                   dist_idx;
    logic                            dist_busy;
    logic                            cfg_wr;

    // Configuration registers.
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius   <= ppl_pkg::LINK_RADIUS_RST;
            r_interval <= ppl_pkg::ADD_INTERVAL_RST;
        end else if (cfg_wr) begin
            if (ppl_pkg::t_reg_idx'(paddr[2]) == ppl_pkg::REG_LINK_RADIUS) begin
                r_radius <= pwdata[RW-1:0];
            end else begin
                r_interval <= pwdata[RW-1:0];
            end
        end
    end

    assign prdata = (ppl_pkg::t_reg_idx'(paddr[2]) == ppl_pkg::REG_LINK_RADIUS)
                  ? ppl_pkg::APB_DATA_W'(r_radius) : ppl_pkg::APB_DATA_W'(r_interval);

    always_ff @(posedge i_clk) begin
        r_r2 <= {{RW{1'b0}}, r_radius} * {{RW{1'b0}}, r_radius};
    end

    // Input decode.
    assign adv       = !r_out_valid || !i_out_stall;
    assign is_clear  = ppl_pkg::t_op'(i_op) == ppl_pkg::OP_CLEAR;
    assign do_add    = !is_clear && (r_phase == '0) && (r_count < CW'(MAX_POINTS));
    assign o_in_stall = (r_state != ppl_pkg::ST_IDLE) || (!adv && !do_add);
    assign accept_in = i_in_valid && !o_in_stall;

    assign in_point = {COORD_BITS'($unsigned(i_pos_z)),
                       COORD_BITS'($unsigned(i_pos_y)),
                       COORD_BITS'($unsigned(i_pos_x))};

    assign interval_eff = (r_interval == '0) ? RW'(1) : r_interval;
    assign phase_inc    = {1'b0, r_phase} + (RW + 1)'(1);
    assign phase_next   = (phase_inc >= {1'b0, interval_eff}) ? '0 : phase_inc[RW-1:0];

    // Ring of point cells; cell 0 feeds the distance unit.
    for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
        ppl_cell #(
            .W (PW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_load      (start && (r_count == CW'(i))),
            .i_shift     (ring_shift),
            .i_load_data (in_point),
            .i_next      (w_cell_data[(i + 1) % MAX_POINTS]),
            .o_data      (w_cell_data[i])
        );
    end

    assign dist_valid = (r_state == ppl_pkg::ST_SCAN) && (CW'(r_scan) < r_new_idx);

    ppl_dist #(
        .COORD_BITS (COORD_BITS),
        .IDX_W      (IW)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (dist_valid),
        .i_idx   (r_scan),
        .i_point (w_cell_data[0]),
        .i_probe (r_probe),
        .i_r2    (r_r2),
        .o_hit   (dist_hit),
        .o_idx   (dist_idx),
        .o_busy  (dist_busy)
    );

    // Sequencer and result assembly. A found pair waits in the pending register
    // until the next pair or the end of the scan tells whether it is the last one.
    always_comb begin
        n_state        = r_state;
        n_count        = r_count;
        n_phase        = r_phase;
        n_scan         = r_scan;
        n_new_idx      = r_new_idx;
        n_pend_v       = r_pend_v;
        n_pend_idx     = r_pend_idx;
        out_load       = 1'b0;
        n_out_added    = 1'b0;
        n_out_has_pair = 1'b0;
        n_out_first    = '0;
        n_out_second   = '0;
        n_out_last     = 1'b0;
        start          = 1'b0;
        ring_shift     = 1'b0;

        case (r_state)
            ppl_pkg::ST_IDLE: begin
                if (accept_in) begin
                    if (is_clear) begin
                        n_count    = '0;
                        out_load   = 1'b1;
                        n_out_last = 1'b1;
                    end else begin
                        n_phase = phase_next;
                        if (do_add) begin
                            start     = 1'b1;
                            n_count   = r_count + CW'(1);
                            n_new_idx = r_count;
                            n_scan    = '0;
                            n_pend_v  = 1'b0;
                            n_state   = ppl_pkg::ST_SCAN;
                        end else begin
                            out_load   = 1'b1;
                            n_out_last = 1'b1;
                        end
                    end
                end
            end
            ppl_pkg::ST_SCAN: begin
                if (adv) begin
                    ring_shift = 1'b1;
                    n_scan     = r_scan + IW'(1);
                    if (r_scan == SCAN_LAST) begin
                        n_state = ppl_pkg::ST_DRAIN;
                    end
                end
            end
            ppl_pkg::ST_DRAIN: begin
                if (!dist_busy) begin
                    n_state = ppl_pkg::ST_FINAL;
                end
            end
            ppl_pkg::ST_FINAL: begin
                if (adv) begin
                    out_load       = 1'b1;
                    n_out_added    = 1'b1;
                    n_out_has_pair = r_pend_v;
                    n_out_first    = r_pend_v ? ppl_pkg::IDX_OUT_W'(r_pend_idx) : '0;
                    n_out_second   = r_pend_v ? ppl_pkg::IDX_OUT_W'(r_new_idx) : '0;
                    n_out_last     = 1'b1;
                    n_state        = ppl_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ppl_pkg::ST_IDLE;
            end
        endcase

        if (adv && dist_hit) begin
            n_pend_v   = 1'b1;
            n_pend_idx = dist_idx;
            if (r_pend_v) begin
                out_load       = 1'b1;
                n_out_added    = 1'b1;
                n_out_has_pair = 1'b1;
                n_out_first    = ppl_pkg::IDX_OUT_W'(r_pend_idx);
                n_out_second   = ppl_pkg::IDX_OUT_W'(r_new_idx);
                n_out_last     = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ppl_pkg::ST_IDLE;
            r_count     <= '0;
            r_phase     <= '0;
            r_scan      <= '0;
            r_new_idx   <= '0;
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_phase   <= n_phase;
            r_scan    <= n_scan;
            r_new_idx <= n_new_idx;
            r_pend_v  <= n_pend_v;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_idx <= n_pend_idx;
        if (start) begin
            r_probe <= in_point;
        end
        if (out_load) begin
            r_out_added    <= n_out_added;
            r_out_has_pair <= n_out_has_pair;
            r_out_first    <= n_out_first;
            r_out_second   <= n_out_second;
            r_out_count    <= ppl_pkg::CNT_OUT_W'(n_count);
            r_out_last     <= n_out_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_added        = r_out_added;
    assign o_has_pair     = r_out_has_pair;
    assign o_first_index  = r_out_first;
    assign o_second_index = r_out_second;
    assign o_point_count  = r_out_count;
    assign o_last         = r_out_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_POINTS))
        else $error("Point count exceeds the store depth.");

    a_final_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ppl_pkg::ST_FINAL) && adv |=> o_out_valid && o_last)
        else $error("Scan ended without a final result.");

    a_pend_older: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_v |-> (CW'(r_pend_idx) < r_new_idx))
        else $error("Pending pair does not point at an older entry.");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept_in && is_clear |=> r_count == '0)
        else $error("Clear did not empty the store.");

endmodule
